@@ hw/rtl/dpec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpec_pkg
// Shared constants, types and helper functions of the disc pair collision
// pipeline.
// ----------------------------------------------------------------------------
package dpec_pkg;

   localparam int WORD_BITS   = 32;
   localparam int UNIT_BITS   = 28;
   localparam int EPS_BITS    = 17;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;
   // front (3) + root (SQRT_STAGES) + setup (2) + divide (DIV_STAGES) + back (13)
   localparam int PIPE_DEPTH  = 3 + SQRT_STAGES + 2 + DIV_STAGES + 13;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] avx;
      logic signed [31:0] avy;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bvx;
      logic signed [31:0] bvy;
      logic               dx_neg;
      logic               dy_neg;
      logic        [31:0] adx;
      logic        [31:0] ady;
      logic        [31:0] rsum;
      logic        [30:0] u;
      logic        [30:0] w;
      logic        [30:0] ma;
      logic        [30:0] mb;
      logic               z0;
      logic               hit;
   } side_type;

   // Round half away from zero, dropping UNIT_BITS fraction bits.
   function automatic logic signed [39:0] rnd_unit(input logic signed [67:0] x);
      logic signed [67:0] t;
      t = x + (x[67] ? 68'sd134217727 : 68'sd134217728);
      return t[67:28];
   endfunction

   // Clamp to the signed word range.
   function automatic logic signed [31:0] sat_word(input logic signed [39:0] x);
      logic signed [31:0] r;
      if (x > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/disc_pair_elastic_collision.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disc_pair_elastic_collision
// Overlap test, separation and elastic velocity exchange for a pair of discs
// in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve req_ fields and pulse start; a word is taken at every
//   clock edge with start high and busy low. busy is always low: the pipe
//   takes a new pair every cycle, so throughput is one word per clock.
//   Each result word appears on the rsp_ ports for exactly one cycle with
//   rsp_valid high. Between the request word and its result lies the
//   chain of units: 3 front stages, a 32-stage square root (one root bit
//   per stage), 2 setup stages, a 31-stage divider (one quotient bit per
//   stage) and 13 back stages for separation, projection and exchange.
//   Results leave in request order; the receiver cannot stall, so the pipe
//   never holds.
//   csr_wr_en/csr_wr_data write axis_epsilon; write it only while no word
//   is in flight. Synchronous reset drops all words in flight and sets
//   axis_epsilon to 1.
// ----------------------------------------------------------------------------
module disc_pair_elastic_collision (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_a_pos_x,
   input  wire logic signed [31:0] req_a_pos_y,
   input  wire logic signed [31:0] req_a_vel_x,
   input  wire logic signed [31:0] req_a_vel_y,
   input  wire logic        [30:0] req_a_radius,
   input  wire logic        [30:0] req_a_mass,
   input  wire logic signed [31:0] req_b_pos_x,
   input  wire logic signed [31:0] req_b_pos_y,
   input  wire logic signed [31:0] req_b_vel_x,
   input  wire logic signed [31:0] req_b_vel_y,
   input  wire logic        [30:0] req_b_radius,
   input  wire logic        [30:0] req_b_mass,
   input  wire logic               csr_wr_en,
   input  wire logic        [16:0] csr_wr_data,
   output logic                    rsp_valid,
   output logic signed      [31:0] rsp_a_new_x,
   output logic signed      [31:0] rsp_a_new_y,
   output logic signed      [31:0] rsp_a_new_vx,
   output logic signed      [31:0] rsp_a_new_vy,
   output logic signed      [31:0] rsp_b_new_x,
   output logic signed      [31:0] rsp_b_new_y,
   output logic signed      [31:0] rsp_b_new_vx,
   output logic signed      [31:0] rsp_b_new_vy,
   output logic                    rsp_hit
);

   // ---------------- control ----------------
   logic [dpec_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [dpec_pkg::EPS_BITS-1:0]   eps_ff, eps_in;

   assign busy = 1'b0;

   // ---------------- stage registers ----------------
   dpec_pkg::side_type side1_ff, side1_in, side2_ff, side3_ff, side3_in;
   logic [63:0] sx2_ff, sy2_ff, rr2_ff;
   logic [61:0] uu2_ff, ww2_ff;
   logic [63:0] sq3_ff, sq3_in;
   logic [62:0] q23_ff, q23_in;

   dpec_pkg::side_type sqd_ff [dpec_pkg::SQRT_STAGES];
   logic [31:0] len0_w, len_w;

   dpec_pkg::side_type side4a_ff, side4a_in, side4b_ff;
   logic [31:0] d4a_ff, d4a_in;
   logic [32:0] dp4a_ff, dp4a_in, dc4a_ff, dc4a_in, df4a_ff, df4a_in;
   logic [63:0] np4b_ff, nq4b_ff, nc4b_ff, ns4b_ff, nf4b_ff;
   logic [32:0] dp4b_ff, dc4b_ff, df4b_ff;

   dpec_pkg::side_type dvd_ff [dpec_pkg::DIV_STAGES];
   logic [30:0] qpx_w, qpy_w, qc_w, qs_w, qf_w;

   dpec_pkg::side_type side5_ff, side5_in, side6_ff, side7_ff, side8_ff, side9_ff;
   dpec_pkg::side_type side10_ff, side11_ff, side12_ff, side13_ff, side14_ff;
   dpec_pkg::side_type side15_ff, side16_ff;
   logic signed [29:0] cs5_ff, cs5_in, ss5_ff, ss5_in;
   logic [28:0] f5_ff, f5_in;
   logic signed [29:0] cs6_ff, ss6_ff, cs7_ff, ss7_ff, cs8_ff, ss8_ff, cs9_ff, ss9_ff;
   logic signed [29:0] cs10_ff, ss10_ff, cs11_ff, ss11_ff, cs12_ff, ss12_ff;
   logic signed [29:0] cs13_ff, ss13_ff;
   logic [28:0] f6_ff, f7_ff, f8_ff, f9_ff;

   logic signed [61:0] axc6_ff, ays6_ff, bxc6_ff, bys6_ff;
   logic signed [61:0] ayc6_ff, axs6_ff, byc6_ff, bxs6_ff;
   logic signed [62:0] pa7_ff, pb7_ff, ta7_ff, tb7_ff;
   logic signed [33:0] pa8_ff, pb8_ff, ta8_ff, tb8_ff, pa8_in, pb8_in, ta8_in, tb8_in;
   logic signed [33:0] pb9_ff, ta9_ff, tb9_ff, pb10_ff, ta10_ff, tb10_ff;
   logic signed [33:0] pb11_ff, ta11_ff, tb11_ff, ta12_ff, tb12_ff, ta13_ff, tb13_ff;
   logic signed [34:0] dv9_ff, dv10_ff, dv11_ff, dv12_ff;
   logic signed [64:0] fdv10_ff;
   logic signed [35:0] rd11_ff, rd11_in;
   logic signed [36:0] v212_ff, v213_ff, v113_ff, v113_in;
   logic signed [66:0] v1c14_ff, tas14_ff, v1s14_ff, tac14_ff;
   logic signed [66:0] v2c14_ff, tbs14_ff, v2s14_ff, tbc14_ff;
   logic signed [67:0] ax15_ff, ay15_ff, bx15_ff, by15_ff;
   logic signed [39:0] ax16_ff, ay16_ff, bx16_ff, by16_ff;

   logic signed [31:0] ox_ff, oy_ff, ovx_ff, ovy_ff, px_ff, py_ff, pvx_ff, pvy_ff;
   logic               ohit_ff;

   // ---------------- control registers ----------------
   always_comb begin
      vld_in = {vld_ff[dpec_pkg::PIPE_DEPTH-2:0], start & ~busy};
      eps_in = csr_wr_en ? csr_wr_data : eps_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         eps_ff <= dpec_pkg::EPS_BITS'(1);
      end else begin
         vld_ff <= vld_in;
         eps_ff <= eps_in;
      end
   end

   // ---------------- stage 1: differences, box test, axis magnitudes --------
   always_comb begin
      logic signed [32:0] dx, dy;
      logic [32:0] tx, ty;
      logic [31:0] adx, ady, rsum, u0;
      logic [16:0] eps;
      dx   = {req_a_pos_x[31], req_a_pos_x} - {req_b_pos_x[31], req_b_pos_x};
      dy   = {req_a_pos_y[31], req_a_pos_y} - {req_b_pos_y[31], req_b_pos_y};
      tx   = dx[32] ? 33'd0 - dx : dx;
      ty   = dy[32] ? 33'd0 - dy : dy;
      adx  = tx[31:0];
      ady  = ty[31:0];
      rsum = {1'b0, req_a_radius} + {1'b0, req_b_radius};
      // an epsilon of zero acts as one
      eps  = (eps_ff == '0) ? 17'd1 : eps_ff;
      u0   = (adx < {15'b0, eps}) ? {15'b0, eps} : adx;

      side1_in.ax     = req_a_pos_x;
      side1_in.ay     = req_a_pos_y;
      side1_in.avx    = req_a_vel_x;
      side1_in.avy    = req_a_vel_y;
      side1_in.bx     = req_b_pos_x;
      side1_in.by     = req_b_pos_y;
      side1_in.bvx    = req_b_vel_x;
      side1_in.bvy    = req_b_vel_y;
      side1_in.dx_neg = dx[32];
      side1_in.dy_neg = dy[32];
      side1_in.adx    = adx;
      side1_in.ady    = ady;
      side1_in.rsum   = rsum;
      // halve both axis components when either one is too wide
      if (u0[31] | ady[31]) begin
         side1_in.u = u0[31:1];
         side1_in.w = ady[31:1];
      end else begin
         side1_in.u = u0[30:0];
         side1_in.w = ady[30:0];
      end
      side1_in.ma  = (req_a_mass == '0) ? 31'd1 : req_a_mass;
      side1_in.mb  = (req_b_mass == '0) ? 31'd1 : req_b_mass;
      side1_in.z0  = 1'b0;
      side1_in.hit = (adx <= rsum) && (ady <= rsum);
   end

   // ---------------- stage 3: distance compare, root operands ----------------
   always_comb begin
      logic [64:0] sq;
      sq           = {1'b0, sx2_ff} + {1'b0, sy2_ff};
      side3_in     = side2_ff;
      side3_in.hit = side2_ff.hit && (sq <= {1'b0, rr2_ff});
      sq3_in       = sq[63:0];
      q23_in       = {1'b0, uu2_ff} + {1'b0, ww2_ff};
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      // stage 2: squares
      side2_ff <= side1_ff;
      sx2_ff   <= side1_ff.adx * side1_ff.adx;
      sy2_ff   <= side1_ff.ady * side1_ff.ady;
      rr2_ff   <= side1_ff.rsum * side1_ff.rsum;
      uu2_ff   <= side1_ff.u * side1_ff.u;
      ww2_ff   <= side1_ff.w * side1_ff.w;
      side3_ff <= side3_in;
      sq3_ff   <= sq3_in;
      q23_ff   <= q23_in;
   end

   // ---------------- square roots: centre distance and axis length ----------
   dpec_isqrt u_root_dist (
      .clock (clock),
      .rad   (sq3_ff),
      .root  (len0_w)
   );

   dpec_isqrt u_root_axis (
      .clock (clock),
      .rad   ({1'b0, q23_ff}),
      .root  (len_w)
   );

   // advance the side word alongside the root pipe
   always_ff @(posedge clock) begin
      sqd_ff[0] <= side3_ff;
      for (int k = 1; k < dpec_pkg::SQRT_STAGES; k++) begin
         sqd_ff[k] <= sqd_ff[k-1];
      end
   end

   // ---------------- stage 4a: overlap depth and divisors ----------------
   always_comb begin
      logic [31:0] lenq;
      logic [31:0] msum;
      side4a_in    = sqd_ff[dpec_pkg::SQRT_STAGES-1];
      // coincident centres: no push
      side4a_in.z0 = (len0_w == '0);
      d4a_in       = sqd_ff[dpec_pkg::SQRT_STAGES-1].rsum - len0_w;
      dp4a_in      = {len0_w, 1'b0};
      lenq         = (len_w == '0) ? 32'd1 : len_w;
      dc4a_in      = {1'b0, lenq};
      msum         = {1'b0, sqd_ff[dpec_pkg::SQRT_STAGES-1].ma}
                   + {1'b0, sqd_ff[dpec_pkg::SQRT_STAGES-1].mb};
      df4a_in      = {1'b0, msum};
   end

   always_ff @(posedge clock) begin
      side4a_ff <= side4a_in;
      d4a_ff    <= d4a_in;
      dp4a_ff   <= dp4a_in;
      dc4a_ff   <= dc4a_in;
      df4a_ff   <= df4a_in;
      // stage 4b: push numerators and unit-vector dividends
      side4b_ff <= side4a_ff;
      np4b_ff   <= d4a_ff * side4a_ff.adx;
      nq4b_ff   <= d4a_ff * side4a_ff.ady;
      nc4b_ff   <= {5'b0, side4a_ff.u, 28'b0};
      ns4b_ff   <= {5'b0, side4a_ff.w, 28'b0};
      nf4b_ff   <= {4'b0, side4a_ff.ma, 29'b0};
      dp4b_ff   <= dp4a_ff;
      dc4b_ff   <= dc4a_ff;
      df4b_ff   <= df4a_ff;
   end

   // ---------------- dividers: push, cosine, sine, mass ratio ----------------
   dpec_div u_div_px (.clock(clock), .num(np4b_ff), .den(dp4b_ff), .quot(qpx_w));
   dpec_div u_div_py (.clock(clock), .num(nq4b_ff), .den(dp4b_ff), .quot(qpy_w));
   dpec_div u_div_c  (.clock(clock), .num(nc4b_ff), .den(dc4b_ff), .quot(qc_w));
   dpec_div u_div_s  (.clock(clock), .num(ns4b_ff), .den(dc4b_ff), .quot(qs_w));
   dpec_div u_div_f  (.clock(clock), .num(nf4b_ff), .den(df4b_ff), .quot(qf_w));

   always_ff @(posedge clock) begin
      dvd_ff[0] <= side4b_ff;
      for (int k = 1; k < dpec_pkg::DIV_STAGES; k++) begin
         dvd_ff[k] <= dvd_ff[k-1];
      end
   end

   // ---------------- stage 5: separated positions, signed axis ----------------
   always_comb begin
      dpec_pkg::side_type s;
      logic [30:0] pxm, pym;
      logic signed [32:0] nax, nay, nbx, nby;
      logic signed [29:0] sm;
      s   = dvd_ff[dpec_pkg::DIV_STAGES-1];
      pxm = s.z0 ? 31'd0 : qpx_w;
      pym = s.z0 ? 31'd0 : qpy_w;
      // disc a moves along the push, disc b against it
      nax = s.dx_neg ? {s.ax[31], s.ax} - {2'b0, pxm} : {s.ax[31], s.ax} + {2'b0, pxm};
      nbx = s.dx_neg ? {s.bx[31], s.bx} + {2'b0, pxm} : {s.bx[31], s.bx} - {2'b0, pxm};
      nay = s.dy_neg ? {s.ay[31], s.ay} - {2'b0, pym} : {s.ay[31], s.ay} + {2'b0, pym};
      nby = s.dy_neg ? {s.by[31], s.by} + {2'b0, pym} : {s.by[31], s.by} - {2'b0, pym};
      side5_in = s;
      if (s.hit) begin
         side5_in.ax = dpec_pkg::sat_word({{7{nax[32]}}, nax});
         side5_in.ay = dpec_pkg::sat_word({{7{nay[32]}}, nay});
         side5_in.bx = dpec_pkg::sat_word({{7{nbx[32]}}, nbx});
         side5_in.by = dpec_pkg::sat_word({{7{nby[32]}}, nby});
      end
      cs5_in = {1'b0, qc_w[28:0]};
      sm     = {1'b0, qs_w[28:0]};
      ss5_in = (s.dy_neg != s.dx_neg) ? -sm : sm;
      f5_in  = qf_w[28:0];
   end

   // ---------------- stages 8, 11, 13: rounding and exchange ----------------
   always_comb begin
      logic signed [39:0] r;
      r      = dpec_pkg::rnd_unit({{5{pa7_ff[62]}}, pa7_ff});
      pa8_in = r[33:0];
      r      = dpec_pkg::rnd_unit({{5{pb7_ff[62]}}, pb7_ff});
      pb8_in = r[33:0];
      r      = dpec_pkg::rnd_unit({{5{ta7_ff[62]}}, ta7_ff});
      ta8_in = r[33:0];
      r      = dpec_pkg::rnd_unit({{5{tb7_ff[62]}}, tb7_ff});
      tb8_in = r[33:0];
      r       = dpec_pkg::rnd_unit({{3{fdv10_ff[64]}}, fdv10_ff});
      rd11_in = r[35:0];
   end

   always_comb begin
      logic signed [37:0] t;
      t       = {v212_ff[36], v212_ff} - {{3{dv12_ff[34]}}, dv12_ff};
      v113_in = t[36:0];
   end

   always_ff @(posedge clock) begin
      side5_ff <= side5_in;
      cs5_ff   <= cs5_in;
      ss5_ff   <= ss5_in;
      f5_ff    <= f5_in;

      // stage 6: project both velocities onto the contact axis
      side6_ff <= side5_ff;
      cs6_ff   <= cs5_ff;
      ss6_ff   <= ss5_ff;
      f6_ff    <= f5_ff;
      axc6_ff  <= side5_ff.avx * cs5_ff;
      ays6_ff  <= side5_ff.avy * ss5_ff;
      bxc6_ff  <= side5_ff.bvx * cs5_ff;
      bys6_ff  <= side5_ff.bvy * ss5_ff;
      ayc6_ff  <= side5_ff.avy * cs5_ff;
      axs6_ff  <= side5_ff.avx * ss5_ff;
      byc6_ff  <= side5_ff.bvy * cs5_ff;
      bxs6_ff  <= side5_ff.bvx * ss5_ff;

      // stage 7: normal and tangential sums
      side7_ff <= side6_ff;
      cs7_ff   <= cs6_ff;
      ss7_ff   <= ss6_ff;
      f7_ff    <= f6_ff;
      pa7_ff   <= {axc6_ff[61], axc6_ff} + {ays6_ff[61], ays6_ff};
      pb7_ff   <= {bxc6_ff[61], bxc6_ff} + {bys6_ff[61], bys6_ff};
      ta7_ff   <= {ayc6_ff[61], ayc6_ff} - {axs6_ff[61], axs6_ff};
      tb7_ff   <= {byc6_ff[61], byc6_ff} - {bxs6_ff[61], bxs6_ff};

      // stage 8: round to Q16.16
      side8_ff <= side7_ff;
      cs8_ff   <= cs7_ff;
      ss8_ff   <= ss7_ff;
      f8_ff    <= f7_ff;
      pa8_ff   <= pa8_in;
      pb8_ff   <= pb8_in;
      ta8_ff   <= ta8_in;
      tb8_ff   <= tb8_in;

      // stage 9: closing speed
      side9_ff <= side8_ff;
      cs9_ff   <= cs8_ff;
      ss9_ff   <= ss8_ff;
      f9_ff    <= f8_ff;
      dv9_ff   <= {pa8_ff[33], pa8_ff} - {pb8_ff[33], pb8_ff};
      pb9_ff   <= pb8_ff;
      ta9_ff   <= ta8_ff;
      tb9_ff   <= tb8_ff;

      // stage 10: scale by the mass ratio
      side10_ff <= side9_ff;
      cs10_ff   <= cs9_ff;
      ss10_ff   <= ss9_ff;
      fdv10_ff  <= $signed({1'b0, f9_ff}) * dv9_ff;
      dv10_ff   <= dv9_ff;
      pb10_ff   <= pb9_ff;
      ta10_ff   <= ta9_ff;
      tb10_ff   <= tb9_ff;

      // stage 11: round the scaled speed
      side11_ff <= side10_ff;
      cs11_ff   <= cs10_ff;
      ss11_ff   <= ss10_ff;
      rd11_ff   <= rd11_in;
      dv11_ff   <= dv10_ff;
      pb11_ff   <= pb10_ff;
      ta11_ff   <= ta10_ff;
      tb11_ff   <= tb10_ff;

      // stage 12: new normal speed of disc b
      side12_ff <= side11_ff;
      cs12_ff   <= cs11_ff;
      ss12_ff   <= ss11_ff;
      v212_ff   <= {{3{pb11_ff[33]}}, pb11_ff} + {rd11_ff[35], rd11_ff};
      dv12_ff   <= dv11_ff;
      ta12_ff   <= ta11_ff;
      tb12_ff   <= tb11_ff;

      // stage 13: new normal speed of disc a
      side13_ff <= side12_ff;
      cs13_ff   <= cs12_ff;
      ss13_ff   <= ss12_ff;
      v113_ff   <= v113_in;
      v213_ff   <= v212_ff;
      ta13_ff   <= ta12_ff;
      tb13_ff   <= tb12_ff;

      // stage 14: rotate back to x/y
      side14_ff <= side13_ff;
      v1c14_ff  <= v113_ff * cs13_ff;
      tas14_ff  <= ta13_ff * ss13_ff;
      v1s14_ff  <= v113_ff * ss13_ff;
      tac14_ff  <= ta13_ff * cs13_ff;
      v2c14_ff  <= v213_ff * cs13_ff;
      tbs14_ff  <= tb13_ff * ss13_ff;
      v2s14_ff  <= v213_ff * ss13_ff;
      tbc14_ff  <= tb13_ff * cs13_ff;

      // stage 15: combine normal and tangential parts
      side15_ff <= side14_ff;
      ax15_ff   <= {v1c14_ff[66], v1c14_ff} - {tas14_ff[66], tas14_ff};
      ay15_ff   <= {v1s14_ff[66], v1s14_ff} + {tac14_ff[66], tac14_ff};
      bx15_ff   <= {v2c14_ff[66], v2c14_ff} - {tbs14_ff[66], tbs14_ff};
      by15_ff   <= {v2s14_ff[66], v2s14_ff} + {tbc14_ff[66], tbc14_ff};

      // stage 16: round
      side16_ff <= side15_ff;
      ax16_ff   <= dpec_pkg::rnd_unit(ax15_ff);
      ay16_ff   <= dpec_pkg::rnd_unit(ay15_ff);
      bx16_ff   <= dpec_pkg::rnd_unit(bx15_ff);
      by16_ff   <= dpec_pkg::rnd_unit(by15_ff);

      // stage 17: saturate; a miss passes the input velocities through
      ox_ff   <= side16_ff.ax;
      oy_ff   <= side16_ff.ay;
      px_ff   <= side16_ff.bx;
      py_ff   <= side16_ff.by;
      ovx_ff  <= side16_ff.hit ? dpec_pkg::sat_word(ax16_ff) : side16_ff.avx;
      ovy_ff  <= side16_ff.hit ? dpec_pkg::sat_word(ay16_ff) : side16_ff.avy;
      pvx_ff  <= side16_ff.hit ? dpec_pkg::sat_word(bx16_ff) : side16_ff.bvx;
      pvy_ff  <= side16_ff.hit ? dpec_pkg::sat_word(by16_ff) : side16_ff.bvy;
      ohit_ff <= side16_ff.hit;
   end

   // ---------------- result word ----------------
   assign rsp_valid    = vld_ff[dpec_pkg::PIPE_DEPTH-1];
   assign rsp_a_new_x  = ox_ff;
   assign rsp_a_new_y  = oy_ff;
   assign rsp_a_new_vx = ovx_ff;
   assign rsp_a_new_vy = ovy_ff;
   assign rsp_b_new_x  = px_ff;
   assign rsp_b_new_y  = py_ff;
   assign rsp_b_new_vx = pvx_ff;
   assign rsp_b_new_vy = pvy_ff;
   assign rsp_hit      = ohit_ff;

endmodule
`default_nettype wire

@@ hw/rtl/dpec_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpec_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module dpec_isqrt (
   input  wire logic        clock,
   input  wire logic [63:0] rad,
   output logic      [31:0] root
);

   logic [63:0] val_ff  [dpec_pkg::SQRT_STAGES];
   logic [33:0] rem_ff  [dpec_pkg::SQRT_STAGES];
   logic [31:0] root_ff [dpec_pkg::SQRT_STAGES];
   logic [63:0] val_in  [dpec_pkg::SQRT_STAGES];
   logic [33:0] rem_in  [dpec_pkg::SQRT_STAGES];
   logic [31:0] root_in [dpec_pkg::SQRT_STAGES];

   always_comb begin
      logic [63:0] v;
      logic [33:0] r;
      logic [31:0] q;
      logic [35:0] cur;
      logic [35:0] trial;
      for (int k = 0; k < dpec_pkg::SQRT_STAGES; k++) begin
         if (k == 0) begin
            v = rad;
            r = '0;
            q = '0;
         end else begin
            v = val_ff[k-1];
            r = rem_ff[k-1];
            q = root_ff[k-1];
         end
         // bring down the next two bits, try root*4+1
         cur   = {r, v[63:62]};
         trial = {2'b00, q, 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = 34'(cur - trial);
            root_in[k] = {q[30:0], 1'b1};
         end else begin
            rem_in[k]  = cur[33:0];
            root_in[k] = {q[30:0], 1'b0};
         end
         val_in[k] = {v[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < dpec_pkg::SQRT_STAGES; k++) begin
         val_ff[k]  <= val_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign root = root_ff[dpec_pkg::SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ hw/rtl/dpec_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpec_div
// Pipelined restoring divider: 64-bit dividend, 33-bit divisor, quotient
// known to fit 31 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dpec_div (
   input  wire logic        clock,
   input  wire logic [63:0] num,
   input  wire logic [32:0] den,
   output logic      [30:0] quot
);

   logic [63:0] rem_ff [dpec_pkg::DIV_STAGES];
   logic [32:0] den_ff [dpec_pkg::DIV_STAGES];
   logic [30:0] q_ff   [dpec_pkg::DIV_STAGES];
   logic [63:0] rem_in [dpec_pkg::DIV_STAGES];
   logic [32:0] den_in [dpec_pkg::DIV_STAGES];
   logic [30:0] q_in   [dpec_pkg::DIV_STAGES];

   always_comb begin
      logic [63:0] r;
      logic [32:0] dn;
      logic [30:0] q;
      logic [63:0] sh;
      logic        ge;
      for (int k = 0; k < dpec_pkg::DIV_STAGES; k++) begin
         if (k == 0) begin
            r  = num;
            dn = den;
            q  = '0;
         end else begin
            r  = rem_ff[k-1];
            dn = den_ff[k-1];
            q  = q_ff[k-1];
         end
         sh        = {31'b0, dn} << (dpec_pkg::DIV_STAGES - 1 - k);
         ge        = r >= sh;
         rem_in[k] = ge ? r - sh : r;
         den_in[k] = dn;
         q_in[k]   = {q[29:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < dpec_pkg::DIV_STAGES; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         q_ff[k]   <= q_in[k];
      end
   end

   assign quot = q_ff[dpec_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire
